// File: sv/sorted_priority_table_core_assert.svh
// Assertion macros for the sorted priority table core.
// Expects clk and rst_n in the scope of each use.
`ifndef SORTED_PRIORITY_TABLE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_TABLE_CORE_ASSERT_SVH

// check the consequent in the cycle after the antecedent
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// check the consequent in the same cycle as the antecedent
`define SPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/spt_pkg.sv
// Shared types, codes and constants of the sorted priority table.
// No dependencies; used by spt_cell and sorted_priority_table_core.
package spt_pkg;

    localparam int SPT_DEPTH = 16;
    localparam int POS_W     = 5;
    localparam int CNT_OUT_W = 5;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_UPDATE = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_UPDATE
    } cell_op_t;

    typedef struct packed {
        logic [15:0] prio;
        logic [31:0] tag;
        logic [31:0] price;
    } entry_t;

    typedef struct packed {
        cell_op_t           op;
        entry_t             data;
        logic [POS_W-1:0]   idx;
    } cell_cmd_t;

endpackage

// File: sv/spt_cell.sv
// One slot of the sorted table: holds an entry and shifts with its neighbours.
// Depends on spt_pkg.
module spt_cell
    import spt_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      valid,
    input  logic      ge_left,
    input  entry_t    left,
    input  entry_t    right,
    output logic      ge,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;

    assign ge    = valid && (entry_reg.prio >= cmd.data.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!ge)
                begin
                    entry_next = ge_left ? cmd.data : left;
                end
            end
            CELL_DELETE:
            begin
                if (INDEX >= int'(cmd.idx))
                begin
                    entry_next = right;
                end
            end
            CELL_UPDATE:
            begin
                if (INDEX == int'(cmd.idx))
                begin
                    entry_next.price = cmd.data.price;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: sv/sorted_priority_table_core.sv
// Top level of the sorted priority table: request decode, cell row, result register.
// Depends on spt_pkg, spt_cell and sorted_priority_table_core_assert.svh.
//
//  channel  dir  word fields (low bit up)
//  s_*      in   req_type, priority_req, item_tag, price, position
//  m_*      out  status, count, out_priority, out_tag, out_price
//
// One word per cycle while m_tready is high: every cell updates in the cycle a request is accepted,
// and the result lands in the output register on the same edge.
// Reset clears the entry count and the output valid; the cells keep their data.
// While a result waits and m_tready is low, s_tready is low too.
module sorted_priority_table_core
    import spt_pkg::*;
#(
    parameter int DEPTH = SPT_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // req_type, priority_req, item_tag, price, position
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata   // status, count, out_priority, out_tag, out_price, pad
);

    `include "sorted_priority_table_core_assert.svh"

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int RDN  = (DEPTH < 31) ? DEPTH : 31;

    logic [2:0]       req_type;
    entry_t           req_data;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] idx;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic [87:0]   out_data_reg;

    logic       accept;
    logic       full;
    logic       empty;
    logic       bad_pos;
    logic       rd_ok;
    logic [1:0] status;
    entry_t     rd_entry;
    cell_cmd_t  cmd;

    entry_t cell_q [DEPTH];
    logic   cell_ge [DEPTH];

    assign req_type       = s_tdata[2:0];
    assign req_data.prio  = s_tdata[18:3];
    assign req_data.tag   = s_tdata[50:19];
    assign req_data.price = s_tdata[82:51];
    assign position       = s_tdata[87:83];
    assign idx            = position - POS_W'(1);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign full    = (CMPW'(count_reg) >= CMPW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign bad_pos = (position == '0) || (CMPW'(position) > CMPW'(count_reg));

    always_comb
    begin
        status     = ST_OK;
        count_next = count_reg;
        rd_ok      = 1'b0;
        cmd.op     = CELL_HOLD;
        cmd.data   = req_data;
        cmd.idx    = idx;
        case (req_type)
            REQ_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.op     = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_DELETE, REQ_UPDATE, REQ_READ:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (bad_pos)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    case (req_type)
                        REQ_DELETE:
                        begin
                            cmd.op     = CELL_DELETE;
                            count_next = count_reg - CW'(1);
                        end
                        REQ_UPDATE:
                        begin
                            cmd.op = CELL_UPDATE;
                        end
                        default:
                        begin
                            rd_ok = 1'b1;
                        end
                    endcase
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
            end
        endcase
        if (!accept)
        begin
            cmd.op = CELL_HOLD;
        end
    end

    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < RDN; i++)
        begin
            if (rd_ok && (idx == POS_W'(i)))
            begin
                rd_entry = cell_q[i];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        spt_cell #(
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .valid   (CW'(g) < count_reg),
            .ge_left ((g == 0) ? 1'b1 : cell_ge[(g == 0) ? 0 : g - 1]),
            .left    (cell_q[(g == 0) ? 0 : g - 1]),
            .right   (cell_q[(g == DEPTH - 1) ? g : g + 1]),
            .ge      (cell_ge[g]),
            .entry   (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {1'b0, rd_entry.price, rd_entry.tag, rd_entry.prio,
                             CNT_OUT_W'(count_next), status};
        end
    end

    `SPT_ASSERT_SAME(a_count_bound, 1'b1, CMPW'(count_reg) <= CMPW'(DEPTH),
        "entry count beyond depth")
    `SPT_ASSERT_NEXT(a_full_insert, accept && (req_type == REQ_INSERT) && full,
        $stable(count_reg) && m_tvalid && (m_tdata[1:0] == ST_FULL),
        "insert into full table altered count or missed status")
    `SPT_ASSERT_NEXT(a_clear, accept && (req_type == REQ_CLEAR),
        (count_reg == '0) && (m_tdata[6:2] == '0), "clear left entries")
    `SPT_ASSERT_SAME(a_err_zero, m_tvalid && (m_tdata[1:0] != ST_OK),
        m_tdata[86:7] == '0, "error result carries entry data")

endmodule

// File: test/tb_top.sv
// Self-checking testbench for sorted_priority_table_core: directed and random request words
// against a behavioural copy of the sorted table, with random idling on both streams.
// Depends on spt_pkg and the sorted_priority_table_core RTL.
`timescale 1ns / 100ps

module tb_top;
    import spt_pkg::*;

    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // request word, position in the top bits down to req_type in the lowest
    typedef struct packed {
        logic [4:0]  pos;
        logic [31:0] price;
        logic [31:0] tag;
        logic [15:0] prio;
        logic [2:0]  kind;
    } request_t;

    // result word, pad bit on top down to status in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [31:0] price;
        logic [31:0] tag;
        logic [15:0] prio;
        logic [4:0]  count;
        logic [1:0]  status;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // req_type, priority_req, item_tag, price, position
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // status, count, out_priority, out_tag, out_price, pad

    logic [15:0] tbl_prio  [SPT_DEPTH];
    logic [31:0] tbl_tag   [SPT_DEPTH];
    logic [31:0] tbl_price [SPT_DEPTH];
    int          tbl_count;

    result_t     pending_results[$];
    int          mismatch_count;
    int          stall_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          rx_stall_left;

    sorted_priority_table_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic result_t table_apply(request_t rq);
        result_t rs;
        int      at;
        int      k;
        int      idx;
        rs = '0;
        case (rq.kind)
            REQ_INSERT:
            begin
                if (tbl_count >= SPT_DEPTH)
                    rs.status = ST_FULL;
                else
                begin
                    at = 0;
                    while (at < tbl_count && tbl_prio[at] >= rq.prio)
                        at++;
                    for (k = tbl_count; k > at; k--)
                    begin
                        tbl_prio[k]  = tbl_prio[k-1];
                        tbl_tag[k]   = tbl_tag[k-1];
                        tbl_price[k] = tbl_price[k-1];
                    end
                    tbl_prio[at]  = rq.prio;
                    tbl_tag[at]   = rq.tag;
                    tbl_price[at] = rq.price;
                    tbl_count++;
                end
            end
            REQ_DELETE, REQ_UPDATE, REQ_READ:
            begin
                if (tbl_count == 0)
                    rs.status = ST_EMPTY;
                else if (rq.pos == 0 || int'(rq.pos) > tbl_count)
                    rs.status = ST_BADPOS;
                else
                begin
                    idx = int'(rq.pos) - 1;
                    if (rq.kind == REQ_DELETE)
                    begin
                        for (k = idx; k < tbl_count - 1; k++)
                        begin
                            tbl_prio[k]  = tbl_prio[k+1];
                            tbl_tag[k]   = tbl_tag[k+1];
                            tbl_price[k] = tbl_price[k+1];
                        end
                        tbl_count--;
                    end
                    else if (rq.kind == REQ_UPDATE)
                        tbl_price[idx] = rq.price;
                    else
                    begin
                        rs.prio  = tbl_prio[idx];
                        rs.tag   = tbl_tag[idx];
                        rs.price = tbl_price[idx];
                    end
                end
            end
            REQ_CLEAR:
                tbl_count = 0;
            default: ;
        endcase
        rs.count = 5'(tbl_count);
        return rs;
    endfunction

    function automatic request_t make_req(logic [2:0] kind, logic [15:0] prio,
                                          logic [31:0] tag, logic [31:0] price,
                                          logic [4:0] pos);
        request_t rq;
        rq.kind  = kind;
        rq.prio  = prio;
        rq.tag   = tag;
        rq.price = price;
        rq.pos   = pos;
        return rq;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // check outgoing words first, then predict the word accepted on this edge
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result word %h", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.count !== want.count ||
                        got.prio !== want.prio || got.tag !== want.tag ||
                        got.price !== want.price)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("result mismatch: status %0d/%0d count %0d/%0d prio %h/%h tag %h/%h price %h/%h (exp/act)",
                                     want.status, got.status, want.count, got.count,
                                     want.prio, got.prio, want.tag, got.tag,
                                     want.price, got.price);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(table_apply(request_t'(s_tdata)));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        m_tready      = 1'b0;
        rx_stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_idle_on && rx_stall_left == 0 && $urandom_range(0, 99) < 25)
                rx_stall_left = pick_gap();
            if (rx_idle_on && rx_stall_left > 0)
            begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_request(request_t rq);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= rq;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_request(make_req(REQ_READ, 16'h0000, 32'h0, 32'h0, 5'd1));
        send_request(make_req(REQ_DELETE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1));
        send_request(make_req(REQ_UPDATE, 16'h0000, 32'h0, 32'hFFFF_FFFF, 5'd0));
        send_request(make_req(REQ_CLEAR, 16'h0000, 32'h0, 32'h0, 5'd31));
        send_request(make_req(REQ_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
        send_request(make_req(REQ_SPARE_HI, 16'h0000, 32'h0, 32'h0, 5'd0));
        wait_results_drained();
    endtask

    task automatic test_fill_and_overflow();
        int i;
        logic [15:0] p;
        for (i = 0; i < SPT_DEPTH; i++)
        begin
            case (i % 4)
                0: p = 16'h0000;
                1: p = 16'hFFFF;
                2: p = 16'h8000;
                default: p = 16'(i * 1000);
            endcase
            send_request(make_req(REQ_INSERT, p, (i == 1) ? 32'hFFFF_FFFF : 32'(i),
                                  (i == 2) ? 32'hFFFF_FFFF : 32'(i << 16), 5'd0));
        end
        send_request(make_req(REQ_INSERT, 16'hFFFF, 32'hDEAD_BEEF, 32'h0001_8000, 5'd0));
        send_request(make_req(REQ_READ, 16'h0, 32'h0, 32'h0, 5'd1));
        send_request(make_req(REQ_READ, 16'h0, 32'h0, 32'h0, 5'd16));
        send_request(make_req(REQ_READ, 16'h0, 32'h0, 32'h0, 5'd0));
        send_request(make_req(REQ_READ, 16'h0, 32'h0, 32'h0, 5'd17));
        send_request(make_req(REQ_UPDATE, 16'h0, 32'h0, 32'hFFFF_FFFF, 5'd16));
        send_request(make_req(REQ_READ, 16'h0, 32'h0, 32'h0, 5'd16));
        send_request(make_req(REQ_DELETE, 16'h0, 32'h0, 32'h0, 5'd1));
        send_request(make_req(REQ_CLEAR, 16'h0, 32'h0, 32'h0, 5'd0));
        wait_results_drained();
    endtask

    task automatic test_random_traffic(int n_items);
        request_t rq;
        int r;
        int i;
        int cnt;
        for (i = 0; i < n_items; i++)
        begin
            cnt = tbl_count;
            r = $urandom_range(0, 99);
            if (r < 38)
                rq.kind = REQ_INSERT;
            else if (r < 55)
                rq.kind = REQ_DELETE;
            else if (r < 67)
                rq.kind = REQ_UPDATE;
            else if (r < 92)
                rq.kind = REQ_READ;
            else if (r < 95)
                rq.kind = REQ_CLEAR;
            else if (r < 97)
                rq.kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
            else
                rq.kind = 3'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 50)
                rq.prio = 16'($urandom_range(0, 65535));
            else if (r < 85)
                rq.prio = 16'($urandom_range(0, 3) << 14);
            else
                rq.prio = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            rq.tag   = $urandom;
            rq.price = $urandom;
            r = $urandom_range(0, 99);
            if (r < 80 && cnt > 0)
                rq.pos = 5'($urandom_range(1, cnt));
            else if (r < 90)
                rq.pos = ($urandom_range(0, 1) != 0) ? 5'(cnt + 1) : 5'd0;
            else
                rq.pos = 5'($urandom_range(0, 31));
            send_request(rq);
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        tbl_count      = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_fill_and_overflow();
        test_random_traffic(500);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(300);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random_traffic(400);

        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
